// File: sv/mrbt_pkg.sv
// shared types, codes and decode helpers for the multi-register block transfer
package mrbt_pkg;

  localparam int unsigned RegCount = 16;
  localparam int unsigned RegIdxW  = $clog2(RegCount);
  localparam int unsigned DataW    = 32;
  localparam int unsigned MaskW    = 16;
  localparam int unsigned CycW     = 7;

  typedef enum logic [1:0] {
    FUNC_WR_REG,
    FUNC_RD_REG,
    FUNC_START,
    FUNC_RET
  } func_e;

  typedef enum logic [1:0] {
    KIND_REG_DATA,
    KIND_BUS_WR,
    KIND_BUS_RD,
    KIND_DONE
  } kind_e;

  localparam logic [2:0] ModePostInc = 3'd3;
  localparam logic [2:0] ModePreDec  = 3'd4;

  typedef struct packed {
    logic latch;
    logic reg_wr;
    logic emit_rd;
    logic start;
    logic step;
    logic fin_start;
    logic ret;
    logic ret_fin;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  to_mem;
    logic  work_empty;
    logic  work_last;
    logic  busy;
    logic  pend_nz;
    logic  pend_last;
    logic  out_free;
  } status_t;

  function automatic logic [CycW-1:0] base_cycles(input logic [2:0] mode,
                                                  input logic [2:0] ar,
                                                  input logic to_mem);
    logic [CycW-1:0] c;
    c = CycW'(8);
    if (to_mem) begin
      unique case (mode)
        3'd2, 3'd4: c = CycW'(8);
        3'd5:       c = CycW'(12);
        3'd6:       c = CycW'(14);
        3'd7: begin
          if (ar == 3'd0) c = CycW'(12);
          else if (ar == 3'd1) c = CycW'(16);
        end
        default:    c = CycW'(8);
      endcase
    end else begin
      unique case (mode)
        3'd2, 3'd3: c = CycW'(12);
        3'd5:       c = CycW'(16);
        3'd6:       c = CycW'(18);
        3'd7: begin
          if (ar == 3'd0) c = CycW'(16);
          else if (ar == 3'd1) c = CycW'(20);
          else if (ar == 3'd2) c = CycW'(16);
          else if (ar == 3'd3) c = CycW'(18);
        end
        default:    c = CycW'(8);
      endcase
    end
    return c;
  endfunction

  function automatic logic [RegIdxW-1:0] lowest_bit(input logic [MaskW-1:0] m);
    logic [RegIdxW-1:0] idx;
    idx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (m[i]) idx = RegIdxW'(i);
    end
    return idx;
  endfunction

endpackage

// File: sv/mrbt_ctrl.sv
// sequencing state machine for register access, transfer walk and read returns
module mrbt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mrbt_pkg::status_t status_i,
  output mrbt_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_RFIN
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status_i.func)
          mrbt_pkg::FUNC_WR_REG: begin
            cmd_o.reg_wr = 1'b1;
            state_d      = ST_IDLE;
          end
          mrbt_pkg::FUNC_RD_REG: begin
            if (status_i.out_free) begin
              cmd_o.emit_rd = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          mrbt_pkg::FUNC_START: begin
            cmd_o.start = 1'b1;
            state_d     = ST_WALK;
          end
          mrbt_pkg::FUNC_RET: begin
            if (status_i.busy && status_i.pend_nz) begin
              cmd_o.ret = 1'b1;
              state_d   = status_i.pend_last ? ST_RFIN : ST_IDLE;
            end else begin
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_WALK: begin
        if (status_i.out_free) begin
          if (status_i.work_empty) begin
            cmd_o.fin_start = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.step = 1'b1;
            if (!status_i.to_mem && status_i.work_last) state_d = ST_IDLE;
          end
        end
      end
      ST_RFIN: begin
        if (status_i.out_free) begin
          cmd_o.ret_fin = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/mrbt_dp.sv
// register file, transfer address and mask registers, and the result word register
module mrbt_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mrbt_pkg::cmd_t                  cmd_i,
  output mrbt_pkg::status_t               status_o,
  input  logic [1:0]                      func_i,
  input  logic [mrbt_pkg::RegIdxW-1:0]    reg_index_i,
  input  logic [mrbt_pkg::DataW-1:0]      data_word_i,
  input  logic [15:0]                     instruction_word_i,
  input  logic [mrbt_pkg::MaskW-1:0]      reg_mask_i,
  input  logic [mrbt_pkg::DataW-1:0]      ea_address_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [1:0]                      kind_o,
  output logic [mrbt_pkg::DataW-1:0]      bus_address_o,
  output logic [mrbt_pkg::DataW-1:0]      out_data_o,
  output logic                            long_access_o,
  output logic [mrbt_pkg::CycW-1:0]       cycle_count_o,
  output logic                            last_o
);

  localparam int unsigned DW = mrbt_pkg::DataW;
  localparam int unsigned IW = mrbt_pkg::RegIdxW;
  localparam int unsigned MW = mrbt_pkg::MaskW;
  localparam int unsigned CW = mrbt_pkg::CycW;

  // latched input word
  logic [1:0]    func_q;
  logic [IW-1:0] idx_q;
  logic [DW-1:0] data_q;
  logic [15:0]   op_q;
  logic [MW-1:0] mask_q;
  logic [DW-1:0] ea_q;

  logic [DW-1:0] rf_q [mrbt_pkg::RegCount];

  // transfer walk
  logic [DW-1:0] addr_q;
  logic [CW-1:0] cyc_q;
  logic [MW-1:0] work_q;

  // pending read state
  logic          busy_q;
  logic [MW-1:0] pend_q;
  logic [DW-1:0] cur_q;
  logic          flag_lng_q;
  logic          flag_pi_q;
  logic [2:0]    flag_ar_q;
  logic [CW-1:0] acc_q;

  // result word register
  logic                out_valid_q;
  mrbt_pkg::kind_e     kind_q;
  logic [DW-1:0]       out_addr_q;
  logic [DW-1:0]       out_data_q;
  logic                out_lng_q;
  logic [CW-1:0]       out_cyc_q;
  logic                out_last_q;

  logic          to_mem, lng, predec_wr, postinc_rd;
  logic [2:0]    mode, ar;
  logic [IW-1:0] an_idx, walk_bit, walk_reg, pend_bit, rd_idx, wa;
  logic [MW-1:0] work_clr, pend_clr;
  logic [DW-1:0] size, ret_size, addr_dn, addr_up, step_addr, start_addr, rd_val, ret_val, wd;
  logic [CW-1:0] base;
  logic          we, emit, out_free;

  assign to_mem     = !op_q[10];
  assign lng        = op_q[6];
  assign mode       = op_q[5:3];
  assign ar         = op_q[2:0];
  assign an_idx     = {1'b1, ar};
  assign predec_wr  = to_mem && (mode == mrbt_pkg::ModePreDec);
  assign postinc_rd = !to_mem && (mode == mrbt_pkg::ModePostInc);
  assign size       = lng ? DW'(4) : DW'(2);
  assign ret_size   = flag_lng_q ? DW'(4) : DW'(2);
  assign base       = mrbt_pkg::base_cycles(mode, ar, to_mem);

  assign walk_bit = mrbt_pkg::lowest_bit(work_q);
  assign walk_reg = predec_wr ? ~walk_bit : walk_bit;
  assign work_clr = work_q & ~(MW'(1) << walk_bit);
  assign pend_bit = mrbt_pkg::lowest_bit(pend_q);
  assign pend_clr = pend_q & ~(MW'(1) << pend_bit);

  assign addr_dn   = addr_q - size;
  assign addr_up   = addr_q + size;
  assign step_addr = predec_wr ? addr_dn : addr_q;

  always_comb begin
    if (cmd_i.start) rd_idx = an_idx;
    else if (cmd_i.step) rd_idx = walk_reg;
    else rd_idx = idx_q;
  end
  assign rd_val     = rf_q[rd_idx];
  assign start_addr = (predec_wr || postinc_rd) ? rd_val : ea_q;
  assign ret_val    = flag_lng_q ? data_q : {{16{data_q[15]}}, data_q[15:0]};

  always_comb begin
    we = 1'b0;
    wa = idx_q;
    wd = data_q;
    priority if (cmd_i.reg_wr) begin
      we = 1'b1;
    end else if (cmd_i.ret) begin
      we = 1'b1;
      wa = pend_bit;
      wd = ret_val;
    end else if (cmd_i.fin_start && predec_wr) begin
      we = 1'b1;
      wa = an_idx;
      wd = addr_q;
    end else if (cmd_i.ret_fin && flag_pi_q) begin
      we = 1'b1;
      wa = {1'b1, flag_ar_q};
      wd = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mrbt_pkg::RegCount; i++) rf_q[i] <= '0;
    end else if (we) begin
      rf_q[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      idx_q  <= reg_index_i;
      data_q <= data_word_i;
      op_q   <= instruction_word_i;
      mask_q <= reg_mask_i;
      ea_q   <= ea_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      cyc_q  <= '0;
      work_q <= '0;
    end else if (cmd_i.start) begin
      addr_q <= start_addr;
      cyc_q  <= base;
      work_q <= mask_q;
    end else if (cmd_i.step) begin
      addr_q <= predec_wr ? addr_dn : addr_up;
      cyc_q  <= cyc_q + size[CW-1:0];
      work_q <= work_clr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pend_q     <= '0;
      cur_q      <= '0;
      flag_lng_q <= 1'b0;
      flag_pi_q  <= 1'b0;
      flag_ar_q  <= '0;
      acc_q      <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b0;
      pend_q <= '0;
      if (!to_mem && (mask_q != '0)) begin
        busy_q     <= 1'b1;
        pend_q     <= mask_q;
        cur_q      <= start_addr;
        flag_lng_q <= lng;
        flag_pi_q  <= postinc_rd;
        flag_ar_q  <= ar;
        acc_q      <= base;
      end
    end else if (cmd_i.ret) begin
      pend_q <= pend_clr;
      cur_q  <= cur_q + ret_size;
      acc_q  <= acc_q + ret_size[CW-1:0];
      if (pend_clr == '0) busy_q <= 1'b0;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = cmd_i.emit_rd || cmd_i.step || cmd_i.fin_start || cmd_i.ret_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_addr_q <= '0;
      out_data_q <= '0;
      out_cyc_q  <= '0;
      out_last_q <= 1'b1;
      priority if (cmd_i.emit_rd) begin
        kind_q     <= mrbt_pkg::KIND_REG_DATA;
        out_data_q <= rd_val;
        out_lng_q  <= 1'b0;
      end else if (cmd_i.step) begin
        kind_q     <= to_mem ? mrbt_pkg::KIND_BUS_WR : mrbt_pkg::KIND_BUS_RD;
        out_addr_q <= step_addr;
        out_lng_q  <= lng;
        out_last_q <= !to_mem && (work_clr == '0);
        if (to_mem) out_data_q <= lng ? rd_val : {16'h0000, rd_val[15:0]};
      end else if (cmd_i.fin_start) begin
        kind_q    <= mrbt_pkg::KIND_DONE;
        out_lng_q <= lng;
        out_cyc_q <= cyc_q;
      end else begin
        kind_q    <= mrbt_pkg::KIND_DONE;
        out_lng_q <= flag_lng_q;
        out_cyc_q <= acc_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign bus_address_o = out_addr_q;
  assign out_data_o    = out_data_q;
  assign long_access_o = out_lng_q;
  assign cycle_count_o = out_cyc_q;
  assign last_o        = out_last_q;

  assign status_o.func       = mrbt_pkg::func_e'(func_q);
  assign status_o.to_mem     = to_mem;
  assign status_o.work_empty = (work_q == '0);
  assign status_o.work_last  = (work_clr == '0);
  assign status_o.busy       = busy_q;
  assign status_o.pend_nz    = (pend_q != '0);
  assign status_o.pend_last  = (pend_clr == '0);
  assign status_o.out_free   = out_free;

endmodule

// File: sv/multi_register_block_transfer_top.sv
// top level of the multi-register block transfer unit
//
// one input channel (in_valid_i/in_ready_o) takes a word carrying func,
// reg_index, data_word, instruction_word, reg_mask and ea_address; one
// output channel (out_valid_o/out_ready_i) gives result words of kind,
// bus_address, out_data, long_access, cycle_count and last
// one input word is handled at a time; in_ready_o is high only when idle
// register write: no result
// register read: one result word
// transfer start with n mask bits: n bus write or read requests, one per
//   cycle from the mask walk while the output register is free; done
//   follows the writes of a store and is the only word of an empty-mask load
// read data return: no result word but on the final datum, which gives done
// the mask walk advances one result word per cycle through a single
//   output register; a stalled receiver halts the walk in place
// reset clears the register file and all transfer state, and drops
//   any pending read
module multi_register_block_transfer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [mrbt_pkg::RegIdxW-1:0]  reg_index_i,
  input  logic [mrbt_pkg::DataW-1:0]    data_word_i,
  input  logic [15:0]                   instruction_word_i,
  input  logic [mrbt_pkg::MaskW-1:0]    reg_mask_i,
  input  logic [mrbt_pkg::DataW-1:0]    ea_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [mrbt_pkg::DataW-1:0]    bus_address_o,
  output logic [mrbt_pkg::DataW-1:0]    out_data_o,
  output logic                          long_access_o,
  output logic [mrbt_pkg::CycW-1:0]     cycle_count_o,
  output logic                          last_o
);

  mrbt_pkg::cmd_t    cmd;
  mrbt_pkg::status_t status;

  mrbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mrbt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .func_i             (func_i),
    .reg_index_i        (reg_index_i),
    .data_word_i        (data_word_i),
    .instruction_word_i (instruction_word_i),
    .reg_mask_i         (reg_mask_i),
    .ea_address_i       (ea_address_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .kind_o             (kind_o),
    .bus_address_o      (bus_address_o),
    .out_data_o         (out_data_o),
    .long_access_o      (long_access_o),
    .cycle_count_o      (cycle_count_o),
    .last_o             (last_o)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == mrbt_pkg::KIND_DONE)) |-> last_o)
    else $error("done word without last");

  a_busy_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> status.pend_nz)
    else $error("reading with empty pending mask");

  a_accept_drops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held after accept");

  a_reg_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == mrbt_pkg::KIND_REG_DATA)) |->
      (!long_access_o && (cycle_count_o == '0) && (bus_address_o == '0)))
    else $error("register read word carries transfer fields");

endmodule

// File: verif/movem_checker.sv
// checker that predicts and compares the result words of the multi-register block transfer
module movem_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    func_i,
  input  logic [mrbt_pkg::RegIdxW-1:0]  reg_index_i,
  input  logic [mrbt_pkg::DataW-1:0]    data_word_i,
  input  logic [15:0]                   instruction_word_i,
  input  logic [mrbt_pkg::MaskW-1:0]    reg_mask_i,
  input  logic [mrbt_pkg::DataW-1:0]    ea_address_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [1:0]                    kind_i,
  input  logic [mrbt_pkg::DataW-1:0]    bus_address_i,
  input  logic [mrbt_pkg::DataW-1:0]    out_data_i,
  input  logic                          long_access_i,
  input  logic [mrbt_pkg::CycW-1:0]     cycle_count_i,
  input  logic                          last_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ModeIndirect = 3'd2;
  localparam logic [2:0] ModeDisp     = 3'd5;
  localparam logic [2:0] ModeIndex    = 3'd6;
  localparam logic [2:0] ModeExt      = 3'd7;
  localparam logic [2:0] ExtAbsShort  = 3'd0;
  localparam logic [2:0] ExtAbsLong   = 3'd1;
  localparam logic [2:0] ExtPcDisp    = 3'd2;
  localparam logic [2:0] ExtPcIndex   = 3'd3;

  typedef struct {
    mrbt_pkg::kind_e                kind;
    logic [mrbt_pkg::DataW-1:0]     addr;
    logic [mrbt_pkg::DataW-1:0]     data;
    logic                           lng;
    logic [mrbt_pkg::CycW-1:0]      cyc;
    logic                           last;
  } xfer_word_t;

  xfer_word_t                   expected_words[$];
  logic [mrbt_pkg::DataW-1:0]   regs[mrbt_pkg::RegCount];
  logic                         reading;
  logic [mrbt_pkg::MaskW-1:0]   pend_mask;
  logic [mrbt_pkg::DataW-1:0]   next_addr;
  logic                         rd_long;
  logic                         rd_postinc;
  logic [2:0]                   rd_areg;
  logic [mrbt_pkg::CycW-1:0]    rd_cycles;

  function automatic logic [mrbt_pkg::CycW-1:0] timing_base(logic [2:0] mode, logic [2:0] ar,
                                                            logic to_mem);
    logic [mrbt_pkg::CycW-1:0] c;
    c = 7'd8;
    if (to_mem) begin
      case (mode)
        ModeDisp:  c = 7'd12;
        ModeIndex: c = 7'd14;
        ModeExt: begin
          if (ar == ExtAbsShort) c = 7'd12;
          else if (ar == ExtAbsLong) c = 7'd16;
        end
        default:   c = 7'd8;
      endcase
    end else begin
      case (mode)
        ModeIndirect, mrbt_pkg::ModePostInc: c = 7'd12;
        ModeDisp:  c = 7'd16;
        ModeIndex: c = 7'd18;
        ModeExt: begin
          case (ar)
            ExtAbsShort: c = 7'd16;
            ExtAbsLong:  c = 7'd20;
            ExtPcDisp:   c = 7'd16;
            ExtPcIndex:  c = 7'd18;
            default:     c = 7'd8;
          endcase
        end
        default:   c = 7'd8;
      endcase
    end
    return c;
  endfunction

  task automatic push_word(mrbt_pkg::kind_e k, logic [mrbt_pkg::DataW-1:0] a,
                           logic [mrbt_pkg::DataW-1:0] d, logic l,
                           logic [mrbt_pkg::CycW-1:0] c, logic lst);
    xfer_word_t w;
    w.kind = k;
    w.addr = a;
    w.data = d;
    w.lng  = l;
    w.cyc  = c;
    w.last = lst;
    expected_words.push_back(w);
  endtask

  task automatic predict_start(logic [15:0] op, logic [mrbt_pkg::MaskW-1:0] mask,
                               logic [mrbt_pkg::DataW-1:0] ea);
    logic                        to_mem;
    logic                        lng;
    logic [2:0]                  mode;
    logic [2:0]                  ar;
    logic [mrbt_pkg::CycW-1:0]   stride;
    logic [mrbt_pkg::CycW-1:0]   cyc;
    logic [mrbt_pkg::DataW-1:0]  addr;
    logic [mrbt_pkg::DataW-1:0]  val;
    int                          left;
    to_mem = !op[10];
    lng    = op[6];
    mode   = op[5:3];
    ar     = op[2:0];
    stride = lng ? 7'd4 : 7'd2;
    cyc    = timing_base(mode, ar, to_mem);
    reading   = 1'b0;
    pend_mask = '0;
    if (to_mem) begin
      addr = (mode == mrbt_pkg::ModePreDec) ? regs[{1'b1, ar}] : ea;
      for (int i = 0; i < 16; i++) begin
        if (mask[i]) begin
          if (mode == mrbt_pkg::ModePreDec) begin
            addr = addr - 32'(stride);
            val  = regs[15 - i];
          end else begin
            val = regs[i];
          end
          push_word(mrbt_pkg::KIND_BUS_WR, addr, lng ? val : {16'h0, val[15:0]}, lng, '0,
                    1'b0);
          if (mode != mrbt_pkg::ModePreDec) addr = addr + 32'(stride);
          cyc = cyc + stride;
        end
      end
      if (mode == mrbt_pkg::ModePreDec) regs[{1'b1, ar}] = addr;
      push_word(mrbt_pkg::KIND_DONE, '0, '0, lng, cyc, 1'b1);
    end else begin
      addr = (mode == mrbt_pkg::ModePostInc) ? regs[{1'b1, ar}] : ea;
      if (mask == '0) begin
        push_word(mrbt_pkg::KIND_DONE, '0, '0, lng, cyc, 1'b1);
      end else begin
        reading    = 1'b1;
        pend_mask  = mask;
        next_addr  = addr;
        rd_long    = lng;
        rd_postinc = (mode == mrbt_pkg::ModePostInc);
        rd_areg    = ar;
        rd_cycles  = cyc;
        left       = $countones(mask);
        for (int i = 0; i < 16; i++) begin
          if (mask[i]) begin
            left--;
            push_word(mrbt_pkg::KIND_BUS_RD, addr, '0, lng, '0, left == 0);
            addr = addr + 32'(stride);
          end
        end
      end
    end
  endtask

  task automatic predict_return(logic [mrbt_pkg::DataW-1:0] d);
    int                          idx;
    logic [mrbt_pkg::CycW-1:0]   stride;
    if (!reading || pend_mask == '0) return;
    idx = 0;
    while (idx < 15 && !pend_mask[idx]) idx++;
    stride = rd_long ? 7'd4 : 7'd2;
    regs[idx] = rd_long ? d : {{16{d[15]}}, d[15:0]};
    next_addr = next_addr + 32'(stride);
    rd_cycles = rd_cycles + stride;
    pend_mask[idx] = 1'b0;
    if (pend_mask == '0) begin
      reading = 1'b0;
      if (rd_postinc) regs[{1'b1, rd_areg}] = next_addr;
      push_word(mrbt_pkg::KIND_DONE, '0, '0, rd_long, rd_cycles, 1'b1);
    end
  endtask

  task automatic check_word();
    xfer_word_t w;
    if (expected_words.size() == 0) begin
      if (fail_count_o < 10)
        $display("%0t unexpected result word: kind %0d addr %h data %h long %0d cyc %0d last %0d",
                 $realtime, kind_i, bus_address_i, out_data_i, long_access_i, cycle_count_i,
                 last_i);
      fail_count_o++;
      return;
    end
    w = expected_words.pop_front();
    if (kind_i !== w.kind || bus_address_i !== w.addr || out_data_i !== w.data ||
        long_access_i !== w.lng || cycle_count_i !== w.cyc || last_i !== w.last) begin
      if (fail_count_o < 10) begin
        $display("%0t result word differs", $realtime);
        $display("  expected: kind %0d addr %h data %h long %0d cyc %0d last %0d",
                 w.kind, w.addr, w.data, w.lng, w.cyc, w.last);
        $display("  actual:   kind %0d addr %h data %h long %0d cyc %0d last %0d",
                 kind_i, bus_address_i, out_data_i, long_access_i, cycle_count_i, last_i);
      end
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mrbt_pkg::RegCount; i++) regs[i] = '0;
      reading      = 1'b0;
      pend_mask    = '0;
      next_addr    = '0;
      rd_long      = 1'b0;
      rd_postinc   = 1'b0;
      rd_areg      = '0;
      rd_cycles    = '0;
      expected_words.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_word();
      if (in_valid_i && in_ready_i) begin
        case (func_i)
          mrbt_pkg::FUNC_WR_REG: regs[reg_index_i] = data_word_i;
          mrbt_pkg::FUNC_RD_REG: push_word(mrbt_pkg::KIND_REG_DATA, '0, regs[reg_index_i],
                                           1'b0, '0, 1'b1);
          mrbt_pkg::FUNC_START:  predict_start(instruction_word_i, reg_mask_i, ea_address_i);
          default:               predict_return(data_word_i);
        endcase
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// File: verif/multi_register_block_transfer_top_tb.sv
// testbench top: drives register access and block transfer words into the unit and gives the verdict
module multi_register_block_transfer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ModeIndirect = 3'd2;
  localparam logic [2:0] ModeDisp     = 3'd5;
  localparam logic [2:0] ModeIndex    = 3'd6;
  localparam logic [2:0] ModeExt      = 3'd7;
  localparam logic [2:0] ExtAbsShort  = 3'd0;
  localparam logic [2:0] ExtAbsLong   = 3'd1;
  localparam logic [2:0] ExtPcIndex   = 3'd3;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    func = '0;
  logic [mrbt_pkg::RegIdxW-1:0]  reg_index = '0;
  logic [mrbt_pkg::DataW-1:0]    data_word = '0;
  logic [15:0]                   instruction_word = '0;
  logic [mrbt_pkg::MaskW-1:0]    reg_mask = '0;
  logic [mrbt_pkg::DataW-1:0]    ea_address = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [1:0]                    kind;
  logic [mrbt_pkg::DataW-1:0]    bus_address;
  logic [mrbt_pkg::DataW-1:0]    out_data;
  logic                          long_access;
  logic [mrbt_pkg::CycW-1:0]     cycle_count;
  logic                          last;
  logic                          steady = 1'b0;
  int unsigned                   fail_count;
  int unsigned                   pending;
  int unsigned                   words_sent = 0;

  multi_register_block_transfer_top dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .func_i             (func),
    .reg_index_i        (reg_index),
    .data_word_i        (data_word),
    .instruction_word_i (instruction_word),
    .reg_mask_i         (reg_mask),
    .ea_address_i       (ea_address),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .kind_o             (kind),
    .bus_address_o      (bus_address),
    .out_data_o         (out_data),
    .long_access_o      (long_access),
    .cycle_count_o      (cycle_count),
    .last_o             (last)
  );

  movem_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .func_i             (func),
    .reg_index_i        (reg_index),
    .data_word_i        (data_word),
    .instruction_word_i (instruction_word),
    .reg_mask_i         (reg_mask),
    .ea_address_i       (ea_address),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .kind_i             (kind),
    .bus_address_i      (bus_address),
    .out_data_i         (out_data),
    .long_access_i      (long_access),
    .cycle_count_i      (cycle_count),
    .last_i             (last),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 27);
  end

  initial begin
    #2000000;
    $display("multi_register_block_transfer_top: mismatch");
    $finish;
  end

  function automatic logic [15:0] movem_op(logic to_reg, logic lng, logic [2:0] mode,
                                           logic [2:0] ar);
    return {5'b01001, to_reg, 3'b001, lng, mode, ar};
  endfunction

  function automatic logic [15:0] random_op(logic to_reg);
    logic [15:0] op;
    op = 16'($urandom);
    op[10] = to_reg;
    if ($urandom_range(1) == 1)
      op[5:3] = to_reg ? mrbt_pkg::ModePostInc : mrbt_pkg::ModePreDec;
    return op;
  endfunction

  function automatic logic [mrbt_pkg::MaskW-1:0] random_mask();
    logic [mrbt_pkg::MaskW-1:0] m;
    case ($urandom_range(9))
      0, 1, 2, 3: m = 16'($urandom);
      4, 5:       m = 16'(1) << $urandom_range(15);
      6:          m = 16'hFFFF;
      7, 8:       m = 16'($urandom & $urandom & $urandom);
      default:    m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [mrbt_pkg::DataW-1:0] random_addr();
    logic [mrbt_pkg::DataW-1:0] a;
    case ($urandom_range(2))
      0:       a = $urandom;
      1:       a = 32'($urandom_range(40));
      default: a = 32'hFFFF_FFFF - 32'($urandom_range(40));
    endcase
    return a;
  endfunction

  task automatic send_word(mrbt_pkg::func_e f, logic [mrbt_pkg::RegIdxW-1:0] idx,
                           logic [mrbt_pkg::DataW-1:0] dat, logic [15:0] op,
                           logic [mrbt_pkg::MaskW-1:0] mask, logic [mrbt_pkg::DataW-1:0] ea);
    while (!steady && $urandom_range(99) < 27) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    func             <= f;
    reg_index        <= idx;
    data_word        <= dat;
    instruction_word <= op;
    reg_mask         <= mask;
    ea_address       <= ea;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic write_reg(logic [mrbt_pkg::RegIdxW-1:0] idx, logic [mrbt_pkg::DataW-1:0] val);
    send_word(mrbt_pkg::FUNC_WR_REG, idx, val, 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic read_reg(logic [mrbt_pkg::RegIdxW-1:0] idx);
    send_word(mrbt_pkg::FUNC_RD_REG, idx, $urandom, 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic start_xfer(logic [15:0] op, logic [mrbt_pkg::MaskW-1:0] mask,
                            logic [mrbt_pkg::DataW-1:0] ea);
    send_word(mrbt_pkg::FUNC_START, 4'($urandom), $urandom, op, mask, ea);
  endtask

  task automatic return_data(logic [mrbt_pkg::DataW-1:0] d);
    send_word(mrbt_pkg::FUNC_RET, 4'($urandom), d, 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic side_access();
    if ($urandom_range(1) == 1) read_reg(4'($urandom));
    else write_reg(4'($urandom), $urandom);
  endtask

  initial begin
    logic [15:0]                 op;
    logic [mrbt_pkg::MaskW-1:0]  mask;
    int unsigned                 goal;
    int                          n;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    read_reg(4'd0);
    write_reg(4'd15, 32'hFFFF_FFFF);
    write_reg(4'd0, 32'h8000_8000);
    write_reg(4'd8, 32'h0000_0010);
    read_reg(4'd15);
    start_xfer(movem_op(1'b0, 1'b1, ModeIndirect, 3'd0), 16'hFFFF, 32'hFFFF_FFF0);
    // pre-decrement store of the base register itself
    start_xfer(movem_op(1'b0, 1'b0, mrbt_pkg::ModePreDec, 3'd7), 16'h0001, 32'h0);
    read_reg(4'd15);
    start_xfer(movem_op(1'b0, 1'b1, ModeExt, ExtAbsShort), 16'h0000, 32'h1234_5678);
    // post-increment load that also loads the base register
    start_xfer(movem_op(1'b1, 1'b0, mrbt_pkg::ModePostInc, 3'd0), 16'h0101, 32'h0);
    return_data(32'h0000_8000);
    return_data(32'h1234_FFFF);
    read_reg(4'd8);
    read_reg(4'd0);
    return_data(32'h0000_ABCD);
    start_xfer(movem_op(1'b1, 1'b1, ModeDisp, 3'd1), 16'h0003, 32'h0000_0100);
    return_data(32'hDEAD_BEEF);
    // abandon the load with an empty-mask load
    start_xfer(movem_op(1'b1, 1'b1, ModeExt, ExtAbsLong), 16'h0000, 32'h0);
    return_data(32'h0000_0001);
    read_reg(4'd1);
    start_xfer(movem_op(1'b1, 1'b1, ModeExt, ExtPcIndex), 16'h8000, 32'hFFFF_FFFC);
    return_data(32'hFFFF_FFFF);
    start_xfer(movem_op(1'b0, 1'b1, ModeExt, ExtAbsLong), 16'h8001, 32'h7FFF_FFFE);
    start_xfer(movem_op(1'b1, 1'b0, ModeIndex, 3'd5), 16'h0001, 32'h0);
    return_data(32'h0000_7FFF);

    goal = words_sent + 200;
    while (words_sent < goal) begin
      steady = (words_sent + 140 > goal) && (words_sent + 100 < goal);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          op   = random_op(1'b1);
          mask = random_mask();
          if (op[5:3] == mrbt_pkg::ModePostInc && $urandom_range(1) == 1)
            write_reg({1'b1, op[2:0]}, random_addr());
          start_xfer(op, mask, random_addr());
          n = $countones(mask);
          for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 4) break;
            if ($urandom_range(99) < 15) side_access();
            return_data($urandom);
          end
        end
        4, 5, 6: begin
          op = random_op(1'b0);
          if (op[5:3] == mrbt_pkg::ModePreDec && $urandom_range(1) == 1)
            write_reg({1'b1, op[2:0]}, random_addr());
          start_xfer(op, random_mask(), random_addr());
        end
        7: write_reg(4'($urandom), ($urandom_range(1) == 1) ? $urandom : random_addr());
        8: read_reg(4'($urandom));
        default: send_word(mrbt_pkg::func_e'($urandom_range(3)), 4'($urandom), $urandom,
                           16'($urandom), 16'($urandom), $urandom);
      endcase
    end
    steady = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("multi_register_block_transfer_top: match");
    end else begin
      $display("multi_register_block_transfer_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mrbt_pkg.sv
sv/mrbt_ctrl.sv
sv/mrbt_dp.sv
sv/multi_register_block_transfer_top.sv
verif/movem_checker.sv
verif/multi_register_block_transfer_top_tb.sv
